[src/fir_filter_q15_unit_defines.svh]
// Assertion macros shared by the FIR filter checker.
`ifndef FIR_FILTER_Q15_UNIT_DEFINES_SVH
`define FIR_FILTER_Q15_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define FFQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FFQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/ffq15_pkg.sv]
// Types and constants for the Q15 FIR filter.
package ffq15_pkg;

    localparam int TAPS_DEF   = 64;
    localparam int FRAC_BITS  = 15;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 6;
    localparam int ACC_W      = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } ffq_state_t;

endpackage

[src/fir_filter_q15_unit.sv]
// Direct-form Q15 FIR filter with one shared multiply-accumulate unit.
//
//  channel   dir  tdata                                          tuser
//  s_        in   sample[15:0] coef_index[21:16] coef_value[37:22] kind
//  m_        out  filtered[15:0]                                 overflow
//
// A sample item is accepted, then runs its TAPS taps through the
// shared multiplier (one tap a cycle from the two tap stores), then drains the
// read and product stages and loads the result. A coefficient write only updates its store.
// Reset clears both stores at once through per-entry valid bits.
// A result waiting on m_tready holds the block before it loads the next one.
module fir_filter_q15_unit #(
    parameter int TAPS = ffq15_pkg::TAPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample, coef_index, coef_value, 2 bits zero pad
    input  logic [ffq15_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // filtered
    output logic [ffq15_pkg::M_TDATA_W-1:0] m_tdata,
    // overflow
    output logic                            m_tuser
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SW = ffq15_pkg::SAMPLE_W;
    localparam int CW = ffq15_pkg::COEF_W;
    localparam int IW = ffq15_pkg::COEF_IDX_W;
    localparam int ACCW = ffq15_pkg::ACC_W;
    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

    ffq15_pkg::ffq_state_t state_reg, state_next;

    logic [SW-1:0] delay_mem [TAPS];
    logic [CW-1:0] coef_mem  [TAPS];
    logic [TAPS-1:0] dvalid_reg;
    logic [TAPS-1:0] cvalid_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] tap_reg, tap_next;

    logic [SW-1:0] dly_rd_reg;
    logic [CW-1:0] coef_rd_reg;
    logic          dly_ok_reg, coef_ok_reg;
    logic          s1_vld_reg, s2_vld_reg;
    logic signed [ACCW-1:0] prod_reg;
    logic [ACCW-1:0]        acc_reg;

    logic                            m_tvalid_reg;
    logic [ffq15_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;

    logic          in_acc;
    logic          smp_acc;
    logic          coef_wr;
    logic          mac_issue;
    logic          pipe_empty;
    logic          out_free;
    logic          load_out;
    logic [SW-1:0] in_sample;
    logic [IW-1:0] in_idx;
    logic [CW-1:0] in_coef;
    logic signed [SW-1:0] op_d;
    logic signed [CW-1:0] op_c;

    assign in_sample = s_tdata[SW-1:0];
    assign in_idx    = s_tdata[SW +: IW];
    assign in_coef   = s_tdata[SW+IW +: CW];

    assign in_acc     = s_tvalid && s_tready;
    assign smp_acc    = in_acc && (s_tuser == ffq15_pkg::KIND_SAMPLE);
    assign coef_wr    = in_acc && (s_tuser == ffq15_pkg::KIND_COEF)
                        && (9'(in_idx) < 9'(TAPS));
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign out_free   = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffq15_pkg::ST_IDLE: begin
                if (smp_acc) begin
                    state_next = ffq15_pkg::ST_MAC;
                end
            end
            ffq15_pkg::ST_MAC: begin
                if (tap_reg == LAST_TAP) begin
                    state_next = ffq15_pkg::ST_DRAIN;
                end
            end
            ffq15_pkg::ST_DRAIN: begin
                if (pipe_empty && out_free) begin
                    state_next = ffq15_pkg::ST_IDLE;
                end
            end
            default: state_next = ffq15_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        mac_issue = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ffq15_pkg::ST_IDLE:  s_tready  = 1'b1;
            ffq15_pkg::ST_MAC:   mac_issue = 1'b1;
            ffq15_pkg::ST_DRAIN: load_out  = pipe_empty && out_free;
            default: ;
        endcase
    end

    // pointers
    always_comb begin
        head_next   = head_reg;
        rd_ptr_next = rd_ptr_reg;
        tap_next    = tap_reg;
        if (smp_acc) begin
            head_next   = (head_reg == LAST_TAP) ? '0 : head_reg + 1'b1;
            rd_ptr_next = head_reg;
            tap_next    = '0;
        end else if (mac_issue) begin
            rd_ptr_next = (rd_ptr_reg == '0) ? LAST_TAP : rd_ptr_reg - 1'b1;
            tap_next    = tap_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ffq15_pkg::ST_IDLE;
            head_reg     <= '0;
            rd_ptr_reg   <= '0;
            tap_reg      <= '0;
            dvalid_reg   <= '0;
            cvalid_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            rd_ptr_reg <= rd_ptr_next;
            tap_reg    <= tap_next;
            s1_vld_reg <= mac_issue;
            s2_vld_reg <= s1_vld_reg;
            if (smp_acc) begin
                dvalid_reg[head_reg] <= 1'b1;
            end
            if (coef_wr) begin
                cvalid_reg[AW'(in_idx)] <= 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // tap stores
    always_ff @(posedge aclk) begin
        if (smp_acc) begin
            delay_mem[head_reg] <= in_sample;
        end
        if (mac_issue) begin
            dly_rd_reg <= delay_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_wr) begin
            coef_mem[AW'(in_idx)] <= in_coef;
        end
        if (mac_issue) begin
            coef_rd_reg <= coef_mem[tap_reg];
        end
    end

    // never-written entries read as zero
    assign op_d = dly_ok_reg  ? $signed(dly_rd_reg)  : '0;
    assign op_c = coef_ok_reg ? $signed(coef_rd_reg) : '0;

    always_ff @(posedge aclk) begin
        if (mac_issue) begin
            dly_ok_reg  <= dvalid_reg[rd_ptr_reg];
            coef_ok_reg <= cvalid_reg[tap_reg];
        end
        prod_reg <= op_d * op_c;
        if (smp_acc) begin
            acc_reg <= '0;
        end else if (s2_vld_reg) begin
            acc_reg <= acc_reg + ACCW'(prod_reg);
        end
        if (load_out) begin
            m_tdata_reg <= acc_reg[ffq15_pkg::FRAC_BITS +: ffq15_pkg::M_TDATA_W];
            m_tuser_reg <= acc_reg[ACCW-1] ^ acc_reg[ACCW-2];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[src/ffq15_checker.sv]
// Port-level checks for the FIR filter, bound to the top level.
`include "fir_filter_q15_unit_defines.svh"

module ffq15_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ffq15_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffq15_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    `FFQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `FFQ_ASSERT_RST(a_rst_clear, !aresetn |=> !m_tvalid, "result valid straight after reset")

    `FFQ_ASSERT(a_coef_silent, s_acc && (s_tuser == ffq15_pkg::KIND_COEF) && !m_tvalid |=> !m_tvalid, "coefficient write gave a result")

    `FFQ_ASSERT(a_busy, s_acc && (s_tuser == ffq15_pkg::KIND_SAMPLE) |=> !s_tready && !m_tvalid || !s_tready && $past(m_tvalid), "ready while filtering")

    `FFQ_ASSERT(a_no_early, s_acc && (s_tuser == ffq15_pkg::KIND_SAMPLE) && !m_tvalid |=> !m_tvalid, "result before filtering done")

endmodule

bind fir_filter_q15_unit ffq15_checker u_ffq15_checker (.*);
